// ----- design/psfc_pkg.sv -----
package psfc_pkg;

    localparam int POS_W        = 6;
    localparam int SLOT_POS_W   = 5;
    localparam int NUM_READINGS = 11;
    localparam int READING_W    = 16;
    localparam int OUT_DATA_W   = 184;

    localparam logic [POS_W-1:0]      IDLE_POS = 6'd32;
    localparam logic [SLOT_POS_W-1:0] LAST_POS = 5'd31;
    localparam logic [SLOT_POS_W-1:0] SUM_LEN  = 5'd30;

    localparam logic [SLOT_POS_W-1:0] POS_START0 = 5'd0;
    localparam logic [SLOT_POS_W-1:0] POS_START1 = 5'd1;
    localparam logic [SLOT_POS_W-1:0] POS_LEN0   = 5'd2;
    localparam logic [SLOT_POS_W-1:0] POS_LEN1   = 5'd3;

    localparam logic [7:0] START0_BYTE = 8'h42;
    localparam logic [7:0] START1_BYTE = 8'h4D;
    localparam logic [7:0] LEN0_BYTE   = 8'h00;
    localparam logic [7:0] LEN1_BYTE   = 8'h1C;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_START = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd3;

    typedef struct packed {
        logic [7:0]            data;
        logic [SLOT_POS_W-1:0] pos;
    } queue_entry_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } slot_sel_t;

    // Odd positions 5..13 and 17..27 complete a big-endian reading.
    function automatic slot_sel_t slot_for(input logic [SLOT_POS_W-1:0] pos);
        slot_sel_t sel;
        sel.hit  = 1'b0;
        sel.slot = 4'd0;
        if (pos[0] && pos >= 5'd5 && pos <= 5'd13)
        begin
            sel.hit  = 1'b1;
            sel.slot = pos[4:1] - 4'd2;
        end
        else if (pos[0] && pos >= 5'd17 && pos <= 5'd27)
        begin
            sel.hit  = 1'b1;
            sel.slot = pos[4:1] - 4'd3;
        end
        return sel;
    endfunction

endpackage

// ----- design/psfc_front.sv -----
module psfc_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_begin,
    input  logic                   queue_ready,
    output logic                   in_ready,
    output logic                   push,
    output psfc_pkg::queue_entry_t push_entry
);

    logic [psfc_pkg::POS_W-1:0] pos_reg;
    logic [psfc_pkg::POS_W-1:0] pos_next;
    logic                       accept;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept && (in_begin || (pos_reg < psfc_pkg::IDLE_POS));

    assign push_entry.data = in_byte;
    assign push_entry.pos  = in_begin ? '0 : pos_reg[psfc_pkg::SLOT_POS_W-1:0];

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (push_entry.pos == psfc_pkg::LAST_POS)
                pos_next = psfc_pkg::IDLE_POS;
            else
                pos_next = {1'b0, push_entry.pos} + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= psfc_pkg::IDLE_POS;
        else
            pos_reg <= pos_next;
    end

endmodule

// ----- design/psfc_queue.sv -----
module psfc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  psfc_pkg::queue_entry_t push_entry,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   pop_valid,
    output psfc_pkg::queue_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psfc_pkg::queue_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = store_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- design/psfc_back.sv -----
module psfc_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                entry_valid,
    input  psfc_pkg::queue_entry_t              entry,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psfc_pkg::OUT_DATA_W-1:0]     out_data
);

    logic [15:0]                    sum_reg;
    logic [15:0]                    sum_next;
    logic                           start_bad_reg;
    logic                           start_bad_next;
    logic                           length_bad_reg;
    logic                           length_bad_next;
    logic [7:0]                     held_reg;
    logic [psfc_pkg::READING_W-1:0] reading_reg [psfc_pkg::NUM_READINGS];
    logic                           out_valid_reg;
    logic [psfc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [psfc_pkg::OUT_DATA_W-1:0] out_data_next;
    logic                           is_last;
    logic                           finish;
    logic [1:0]                     status;
    psfc_pkg::slot_sel_t            sel;

    assign is_last   = (entry.pos == psfc_pkg::LAST_POS);
    assign pop       = entry_valid && (!is_last || !out_valid_reg || out_ready);
    assign finish    = pop && is_last;
    assign sel       = psfc_pkg::slot_for(entry.pos);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        sum_next        = sum_reg;
        start_bad_next  = start_bad_reg;
        length_bad_next = length_bad_reg;
        if (entry.pos == psfc_pkg::POS_START0)
        begin
            sum_next        = {8'h00, entry.data};
            start_bad_next  = (entry.data != psfc_pkg::START0_BYTE);
            length_bad_next = 1'b0;
        end
        else
        begin
            if (entry.pos < psfc_pkg::SUM_LEN)
                sum_next = sum_reg + {8'h00, entry.data};
            if (entry.pos == psfc_pkg::POS_START1 && entry.data != psfc_pkg::START1_BYTE)
                start_bad_next = 1'b1;
            if (entry.pos == psfc_pkg::POS_LEN0 && entry.data != psfc_pkg::LEN0_BYTE)
                length_bad_next = 1'b1;
            if (entry.pos == psfc_pkg::POS_LEN1 && entry.data != psfc_pkg::LEN1_BYTE)
                length_bad_next = 1'b1;
        end
    end

    always_comb
    begin
        if (start_bad_reg)
            status = psfc_pkg::STATUS_BAD_START;
        else if (length_bad_reg)
            status = psfc_pkg::STATUS_BAD_LEN;
        else if ({held_reg, entry.data} != sum_reg)
            status = psfc_pkg::STATUS_BAD_SUM;
        else
            status = psfc_pkg::STATUS_OK;
    end

    always_comb
    begin
        out_data_next      = '0;
        out_data_next[1:0] = status;
        if (status == psfc_pkg::STATUS_OK)
        begin
            for (int i = 0; i < psfc_pkg::NUM_READINGS; i++)
                out_data_next[2 + psfc_pkg::READING_W * i +: psfc_pkg::READING_W] =
                    reading_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            start_bad_reg  <= 1'b0;
            length_bad_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sum_reg        <= sum_next;
                start_bad_reg  <= start_bad_next;
                length_bad_reg <= length_bad_next;
                if (!entry.pos[0])
                    held_reg <= entry.data;
            end
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && sel.hit)
            reading_reg[sel.slot] <= {held_reg, entry.data};
        if (finish)
            out_data_reg <= out_data_next;
    end

endmodule

// ----- design/particle_sensor_frame_checker.sv -----
// Channel  Direction  Ports                          Content
// s_axis   in         tvalid tready tdata tuser      one response byte, frame start flag
// m_axis   out        tvalid tready tdata            frame status and eleven readings
//
// The block takes one byte in every cycle while its byte queue has room.
// A result is written into the result register when the last byte of a frame
// leaves the byte queue, after any bytes still waiting ahead of it have left.
// The back end stalls only on the last byte of a frame while the result
// register still holds an earlier result that has not been taken.
// Reset sets the position counter to idle, empties the queue and clears the result valid flag.
module particle_sensor_frame_checker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
    input  logic         s_axis_tuser,  // [0] frame_begin
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata   // frame_status, pm1_std, pm2_5_std, pm10_std,
                                        // pm1_atm, pm2_5_atm, count_0_3, count_0_5,
                                        // count_1_0, count_2_5, count_5_0, count_10_0,
                                        // zero padding
);

    logic                   queue_ready;
    logic                   push;
    psfc_pkg::queue_entry_t push_entry;
    logic                   pop;
    logic                   pop_valid;
    psfc_pkg::queue_entry_t pop_entry;

    psfc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_byte     (s_axis_tdata),
        .in_begin    (s_axis_tuser),
        .queue_ready (queue_ready),
        .in_ready    (s_axis_tready),
        .push        (push),
        .push_entry  (push_entry)
    );

    psfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    psfc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (pop_valid),
        .entry       (pop_entry),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

// ----- tb/sv/particle_sensor_frame_checker_tb.sv -----
module particle_sensor_frame_checker_tb;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int FRAME_BYTES   = 32;

    typedef enum logic [3:0] {
        FK_GOOD,
        FK_BAD_START0,
        FK_BAD_START1,
        FK_BAD_LEN0,
        FK_BAD_LEN1,
        FK_BAD_BOTH,
        FK_BAD_SUM,
        FK_RESTART,
        FK_IDLE_NOISE,
        FK_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [1:0]                                                 status;
        logic [psfc_pkg::NUM_READINGS-1:0][psfc_pkg::READING_W-1:0] readings;
    } frame_report_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  fill;
        logic [4:0]  cut;
        logic        pinned;
        logic [1:0]  status;
    } plan_row_t;

    // Rows marked pinned carry the status and readings typed in by hand.
    localparam int PLAN_ROWS = 14;
    localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
        '{FK_IDLE_NOISE, 8'h00, 5'd5,  1'b0, psfc_pkg::STATUS_OK},
        '{FK_GOOD,       8'h00, 5'd0,  1'b1, psfc_pkg::STATUS_OK},
        '{FK_IDLE_NOISE, 8'hFF, 5'd3,  1'b0, psfc_pkg::STATUS_OK},
        '{FK_GOOD,       8'hFF, 5'd0,  1'b1, psfc_pkg::STATUS_OK},
        '{FK_BAD_START0, 8'h11, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_START},
        '{FK_BAD_START1, 8'h22, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_START},
        '{FK_BAD_LEN0,   8'h33, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_LEN},
        '{FK_BAD_LEN1,   8'h44, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_LEN},
        '{FK_BAD_BOTH,   8'h55, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_START},
        '{FK_BAD_SUM,    8'h66, 5'd0,  1'b1, psfc_pkg::STATUS_BAD_SUM},
        '{FK_RESTART,    8'h5A, 5'd31, 1'b1, psfc_pkg::STATUS_OK},
        '{FK_RESTART,    8'hA5, 5'd1,  1'b1, psfc_pkg::STATUS_OK},
        '{FK_RESTART,    8'hC3, 5'd14, 1'b0, psfc_pkg::STATUS_OK},
        '{FK_NOISE,      8'h00, 5'd20, 1'b0, psfc_pkg::STATUS_OK}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [psfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    particle_sensor_frame_checker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [psfc_pkg::POS_W-1:0]                                 frame_pos;
    logic [15:0]                                                byte_sum;
    logic                                                       start_err;
    logic                                                       length_err;
    logic [7:0]                                                 upper_byte;
    logic [psfc_pkg::NUM_READINGS-1:0][psfc_pkg::READING_W-1:0] reading_slots;

    frame_report_t frame_reports_due [$];
    frame_report_t pinned_report;
    bit            pinned_on;

    logic [7:0] frame_buf [FRAME_BYTES];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  phase;
    bit  hold_on;
    int  quiet_cycles;
    int  mismatches;
    int  bytes_used;
    int  bytes_ignored;
    int  reports_ok;
    int  reports_rejected;

    string reading_names [psfc_pkg::NUM_READINGS] = '{
        "pm1_std", "pm2_5_std", "pm10_std", "pm1_atm", "pm2_5_atm",
        "count_0_3", "count_0_5", "count_1_0", "count_2_5", "count_5_0", "count_10_0"
    };

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("MISMATCH at %0t: %s got %h, wanted %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Returns 1 when the byte is taken into a frame, 0 when it is dropped while idle.
    function automatic bit track_byte(input logic [7:0] b, input logic begin_flag);
        frame_report_t rep;
        int            p;
        int            slot;
        logic [15:0]   check;
        if (begin_flag)
        begin
            frame_pos  = '0;
            byte_sum   = '0;
            start_err  = 1'b0;
            length_err = 1'b0;
        end
        else if (frame_pos >= psfc_pkg::IDLE_POS)
        begin
            return 1'b0;
        end
        p = int'(frame_pos);
        if (p < int'(psfc_pkg::SUM_LEN))
        begin
            byte_sum = byte_sum + 16'(b);
        end
        if ((p == int'(psfc_pkg::POS_START0) && b != psfc_pkg::START0_BYTE)
            || (p == int'(psfc_pkg::POS_START1) && b != psfc_pkg::START1_BYTE))
        begin
            start_err = 1'b1;
        end
        if ((p == int'(psfc_pkg::POS_LEN0) && b != psfc_pkg::LEN0_BYTE)
            || (p == int'(psfc_pkg::POS_LEN1) && b != psfc_pkg::LEN1_BYTE))
        begin
            length_err = 1'b1;
        end
        slot = -1;
        if (p % 2 == 1 && p >= 5 && p <= 13)
        begin
            slot = (p - 5) / 2;
        end
        else if (p % 2 == 1 && p >= 17 && p <= 27)
        begin
            slot = (p - 7) / 2;
        end
        if (slot >= 0)
        begin
            reading_slots[slot] = {upper_byte, b};
        end
        if (p % 2 == 0)
        begin
            upper_byte = b;
        end
        if (p == int'(psfc_pkg::LAST_POS))
        begin
            check = {upper_byte, b};
            if (start_err)
            begin
                rep.status = psfc_pkg::STATUS_BAD_START;
            end
            else if (length_err)
            begin
                rep.status = psfc_pkg::STATUS_BAD_LEN;
            end
            else if (check != byte_sum)
            begin
                rep.status = psfc_pkg::STATUS_BAD_SUM;
            end
            else
            begin
                rep.status = psfc_pkg::STATUS_OK;
            end
            for (int i = 0; i < psfc_pkg::NUM_READINGS; i++)
            begin
                rep.readings[i] = (rep.status == psfc_pkg::STATUS_OK) ? reading_slots[i] : '0;
            end
            if (pinned_on)
            begin
                rep       = pinned_report;
                pinned_on = 1'b0;
            end
            frame_reports_due.push_back(rep);
            frame_pos = psfc_pkg::IDLE_POS;
        end
        else
        begin
            frame_pos = frame_pos + 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic begin_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= begin_flag;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (track_byte(b, begin_flag))
        begin
            bytes_used++;
        end
        else
        begin
            bytes_ignored++;
        end
    endtask

    function automatic void load_frame(input logic [7:0] fill, input bit scramble);
        logic [15:0] sum;
        sum          = '0;
        frame_buf[0] = psfc_pkg::START0_BYTE;
        frame_buf[1] = psfc_pkg::START1_BYTE;
        frame_buf[2] = psfc_pkg::LEN0_BYTE;
        frame_buf[3] = psfc_pkg::LEN1_BYTE;
        for (int k = 4; k < int'(psfc_pkg::SUM_LEN); k++)
        begin
            frame_buf[k] = scramble ? 8'($urandom) : fill;
        end
        for (int k = 0; k < int'(psfc_pkg::SUM_LEN); k++)
        begin
            sum = sum + 16'(frame_buf[k]);
        end
        frame_buf[30] = sum[15:8];
        frame_buf[31] = sum[7:0];
    endfunction

    task automatic run_case(input frame_kind_t kind, input logic [7:0] fill,
                            input bit scramble, input int cut);
        logic [7:0] flip;
        flip = scramble ? 8'($urandom_range(255, 1)) : 8'hFF;
        load_frame(fill, scramble);
        case (kind)
            FK_BAD_START0: frame_buf[0] ^= flip;
            FK_BAD_START1: frame_buf[1] ^= flip;
            FK_BAD_LEN0:   frame_buf[2] ^= flip;
            FK_BAD_LEN1:   frame_buf[3] ^= flip;
            FK_BAD_BOTH:
            begin
                frame_buf[1] ^= flip;
                frame_buf[3] ^= flip;
            end
            FK_BAD_SUM:    frame_buf[scramble ? 30 + $urandom_range(1) : 31] ^= flip;
            default:       ;
        endcase
        case (kind)
            FK_IDLE_NOISE:
            begin
                for (int k = 0; k < cut; k++)
                begin
                    send_byte(scramble ? 8'($urandom) : fill, 1'b0);
                end
            end
            FK_NOISE:
            begin
                for (int k = 0; k < cut; k++)
                begin
                    send_byte(8'($urandom), $urandom_range(15) == 0);
                end
            end
            default:
            begin
                if (kind == FK_RESTART)
                begin
                    for (int k = 0; k < cut; k++)
                    begin
                        send_byte(frame_buf[k], k == 0);
                    end
                end
                for (int k = 0; k < FRAME_BYTES; k++)
                begin
                    send_byte(frame_buf[k], k == 0);
                end
            end
        endcase
    endtask

    task automatic run_random(input int target);
        int          r;
        frame_kind_t kind;
        int          cut;
        while (bytes_used < target)
        begin
            r   = $urandom_range(99);
            cut = 0;
            if (r < 55)
            begin
                kind = FK_GOOD;
            end
            else if (r < 65)
            begin
                kind = FK_BAD_SUM;
            end
            else if (r < 72)
            begin
                kind = $urandom_range(1) ? FK_BAD_START0 : FK_BAD_START1;
            end
            else if (r < 79)
            begin
                kind = $urandom_range(1) ? FK_BAD_LEN0 : FK_BAD_LEN1;
            end
            else if (r < 82)
            begin
                kind = FK_BAD_BOTH;
            end
            else if (r < 90)
            begin
                kind = FK_RESTART;
                cut  = $urandom_range(31, 1);
            end
            else if (r < 95)
            begin
                kind = FK_IDLE_NOISE;
                cut  = $urandom_range(6, 1);
            end
            else
            begin
                kind = FK_NOISE;
                cut  = $urandom_range(40, 1);
            end
            run_case(kind, 8'($urandom), 1'b1, cut);
        end
    endtask

    always @(posedge clk)
    begin : take_results
        frame_report_t got;
        frame_report_t want;
        m_axis_tready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[1:0];
            for (int i = 0; i < psfc_pkg::NUM_READINGS; i++)
            begin
                got.readings[i] = m_axis_tdata[2 + psfc_pkg::READING_W * i +: psfc_pkg::READING_W];
            end
            if (frame_reports_due.size() == 0)
            begin
                note_mismatch("result with none pending, status", 16'(got.status), 16'h0);
            end
            else
            begin
                want = frame_reports_due.pop_front();
                if (got.status != want.status)
                begin
                    note_mismatch("frame_status", 16'(got.status), 16'(want.status));
                end
                for (int i = 0; i < psfc_pkg::NUM_READINGS; i++)
                begin
                    if (got.readings[i] != want.readings[i])
                    begin
                        note_mismatch(reading_names[i], got.readings[i], want.readings[i]);
                    end
                end
                if (want.status == psfc_pkg::STATUS_OK)
                begin
                    reports_ok++;
                end
                else
                begin
                    reports_rejected++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The output side stops for a long stretch while input keeps coming.
    initial
    begin
        hold_on = 1'b0;
        wait (phase == 2);
        repeat (40) @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        mismatches       = 0;
        bytes_used       = 0;
        bytes_ignored    = 0;
        reports_ok       = 0;
        reports_rejected = 0;
        pinned_on        = 1'b0;
        frame_pos        = psfc_pkg::IDLE_POS;
        byte_sum         = '0;
        start_err        = 1'b0;
        length_err       = 1'b0;
        upper_byte       = '0;
        reading_slots    = '0;
        phase            = 0;
        send_idle_pct    = 29;
        recv_idle_pct    = 49;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].pinned)
            begin
                pinned_report.status = PLAN[r].status;
                for (int i = 0; i < psfc_pkg::NUM_READINGS; i++)
                begin
                    pinned_report.readings[i] = (PLAN[r].status == psfc_pkg::STATUS_OK)
                                              ? {PLAN[r].fill, PLAN[r].fill} : 16'h0;
                end
                pinned_on = 1'b1;
            end
            run_case(PLAN[r].kind, PLAN[r].fill, 1'b0, int'(PLAN[r].cut));
        end
        run_random(700);

        phase         = 1;
        send_idle_pct = 49;
        recv_idle_pct = 29;
        run_random(1125);

        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(1550);
        s_axis_tvalid <= 1'b0;

        while (frame_reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (frame_reports_due.size() != 0)
        begin
            void'(frame_reports_due.pop_front());
            note_mismatch("result never arrived, pending count", 16'h1, 16'h0);
        end

        $display("Ran header, length, checksum, restart, idle-byte and random frame cases");
        $display({"under three handshake mixes and one long output stall: %0d bytes framed, ",
                  "%0d ignored, %0d frames ok, %0d rejected, %0d mismatches"},
                 bytes_used, bytes_ignored, reports_ok, reports_rejected, mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
